// File: rtl/lav_pkg.sv
package lav_pkg;

    localparam int COORD_W  = 32;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int COEF_W   = 32;
    localparam int UNIT_FB  = 30;
    localparam int IN_W     = 6 * COORD_W;
    localparam int OUT_W    = 136;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [COEF_W-1:0]  t_coef;

    // one camera job, eye point plus view difference and degenerate flag
    typedef struct packed {
        t_coord eye_x;
        t_coord eye_y;
        t_coord eye_z;
        t_diff  d_x;
        t_diff  d_y;
        t_diff  d_z;
        logic   deg;
    } t_job;

    // handshake between front, queue and back
    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_bus;

endpackage

// File: rtl/look_at_view_matrix.sv
// channel  dir  tdata (low bit up)                                   tlast     tuser
// s_axis   in   eye_x, eye_y, eye_z, target_x, target_y, target_z     -         -
// m_axis   out  row_index, coeff_x, coeff_y, coeff_z, shift, pad      last_row  degenerate
//
// each item gives three rows, Ex, Ey then Ez
// a normal item passes through the back engine as: per axis vector a scaling walk,
// the squares, the root and three divides; then the cross product and one translation
// pass per row; a degenerate item goes straight to the cross product
// the front and a two entry queue take new items while the back engine works
// reset is synchronous, active low, and empties queue and output register
// a stalled output holds the engine in its emit step
module look_at_view_matrix (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [lav_pkg::IN_W-1:0]   s_axis_tdata,   // eye_x,eye_y,eye_z,target_x,target_y,target_z
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [lav_pkg::OUT_W-1:0]  m_axis_tdata,   // row_index,coeff_x,coeff_y,coeff_z,shift
    output logic                       m_axis_tlast,
    output logic                       m_axis_tuser    // degenerate
);
    import lav_pkg::*;

    t_job_bus w_push;
    t_job_bus w_head;
    logic     w_push_ready;
    logic     w_pop_ready;

    lav_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .o_push       (w_push),
        .i_push_ready (w_push_ready)
    );

    lav_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .o_head       (w_head),
        .i_pop_ready  (w_pop_ready)
    );

    lav_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop_ready (w_pop_ready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .o_deg       (m_axis_tuser)
    );

endmodule

// File: rtl/lav_front.sv
module lav_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [lav_pkg::IN_W-1:0] i_data,
    output lav_pkg::t_job_bus     o_push,
    input  logic                  i_push_ready
);
    import lav_pkg::*;

    logic   r_valid;
    t_job   r_job;
    t_job   n_job;
    t_coord w_tx, w_ty, w_tz;

    assign w_tx = t_coord'(i_data[4*COORD_W-1:3*COORD_W]);
    assign w_ty = t_coord'(i_data[5*COORD_W-1:4*COORD_W]);
    assign w_tz = t_coord'(i_data[6*COORD_W-1:5*COORD_W]);

    always_comb begin
        n_job.eye_x = t_coord'(i_data[COORD_W-1:0]);
        n_job.eye_y = t_coord'(i_data[2*COORD_W-1:COORD_W]);
        n_job.eye_z = t_coord'(i_data[3*COORD_W-1:2*COORD_W]);
        n_job.d_x   = t_diff'(n_job.eye_x) - t_diff'(w_tx);
        n_job.d_y   = t_diff'(n_job.eye_y) - t_diff'(w_ty);
        n_job.d_z   = t_diff'(n_job.eye_z) - t_diff'(w_tz);
        // eye on target, or view along the up axis
        n_job.deg   = (n_job.d_x == '0) && (n_job.d_z == '0);
    end

    assign o_ready      = !r_valid || i_push_ready;
    assign o_push.valid = r_valid;
    assign o_push.job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

// File: rtl/lav_queue.sv
module lav_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lav_pkg::t_job_bus i_push,
    output logic              o_push_ready,
    output lav_pkg::t_job_bus o_head,
    input  logic              i_pop_ready
);
    import lav_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.job   = r_mem[r_rp];
    assign w_push       = i_push.valid && o_push_ready;
    assign w_pop        = o_head.valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wp] <= i_push.job;
        end
    end

endmodule

// File: rtl/lav_back.sv
module lav_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lav_pkg::t_job_bus        i_head,
    output logic                     o_pop_ready,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [lav_pkg::OUT_W-1:0] o_data,
    output logic                     o_last,
    output logic                     o_deg
);
    import lav_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE, S_SQ, S_SQRT, S_DIV, S_CROSS, S_TRANS, S_ROUND, S_EMIT
    } t_state;

    t_state              r_state;
    t_job                r_job;
    logic                r_vec;
    logic        [32:0]  r_m [3];
    logic                r_neg [3];
    logic        [4:0]   r_cnt;
    logic        [1:0]   r_comp;
    logic        [63:0]  r_sum;
    logic        [63:0]  r_rad;
    logic        [32:0]  r_rem;
    logic        [31:0]  r_root;
    logic        [32:0]  r_dr;
    logic        [30:0]  r_q;
    t_coef               r_ez [3];
    t_coef               r_ex [3];
    t_coef               r_ey [3];
    logic signed [63:0]  r_prod;
    logic signed [63:0]  r_tmp;
    logic signed [65:0]  r_acc;
    logic        [1:0]   r_row;
    t_coord              r_shift;

    logic                r_out_valid;
    logic        [1:0]   r_out_row;
    t_coef               r_out_cx, r_out_cy, r_out_cz;
    t_coord              r_out_shift;
    logic                r_out_last;
    logic                r_out_deg;

    logic signed [31:0]  w_mul_a, w_mul_b;
    logic signed [63:0]  w_prod;
    logic                w_hi, w_lo;
    logic        [34:0]  w_sq_rem, w_sq_trial;
    logic        [32:0]  w_dv_m;
    logic        [33:0]  w_dr2;
    logic        [31:0]  w_qr;
    t_coef               w_coef;
    t_coef               w_row_c [3];
    t_coord              w_eye [3];
    logic signed [65:0]  w_tneg;
    logic signed [35:0]  w_ts;
    t_coord              w_sat;
    logic                w_emit;

    function automatic logic [32:0] mag(input t_diff v);
        return v[DIFF_W-1] ? 33'(-v) : 33'(v);
    endfunction

    function automatic t_coef rnd_q(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd536870912;
        return t_coef'(t[61:30]);
    endfunction

    assign w_eye[0] = r_job.eye_x;
    assign w_eye[1] = r_job.eye_y;
    assign w_eye[2] = r_job.eye_z;

    always_comb begin
        case (r_row)
            2'd0:    w_row_c = r_ex;
            2'd1:    w_row_c = r_ey;
            default: w_row_c = r_ez;
        endcase
    end

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_SQ: begin
                if (r_cnt < 5'd3) begin
                    w_mul_a = {1'b0, r_m[r_cnt[1:0]][30:0]};
                    w_mul_b = w_mul_a;
                end
            end
            S_CROSS: begin
                case (r_cnt)
                    5'd0: begin w_mul_a = r_ez[1]; w_mul_b = r_ex[2]; end
                    5'd1: begin w_mul_a = r_ez[2]; w_mul_b = r_ex[0]; end
                    5'd2: begin w_mul_a = r_ez[0]; w_mul_b = r_ex[2]; end
                    5'd3: begin w_mul_a = r_ez[1]; w_mul_b = r_ex[0]; end
                    default: ;
                endcase
            end
            S_TRANS: begin
                if (r_cnt < 5'd3) begin
                    w_mul_a = w_row_c[r_cnt[1:0]];
                    w_mul_b = w_eye[r_cnt[1:0]];
                end
            end
            default: ;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign w_hi = |{r_m[0][32:31], r_m[1][32:31], r_m[2][32:31]};
    assign w_lo = ~|{r_m[0][32:30], r_m[1][32:30], r_m[2][32:30]};

    assign w_sq_rem   = {r_rem, r_rad[63:62]};
    assign w_sq_trial = {1'b0, r_root, 2'b01};

    assign w_dv_m = r_m[r_comp];
    assign w_dr2  = {r_dr, 1'b0};
    assign w_qr   = {1'b0, r_q} + 32'(w_dr2 >= {2'b0, r_root});
    assign w_coef = r_neg[r_comp] ? t_coef'(-w_qr) : t_coef'(w_qr);

    assign w_tneg = -r_acc + 66'sd536870912;
    assign w_ts   = w_tneg[65:30];
    always_comb begin
        if (!w_ts[35] && (w_ts[34:31] != '0)) begin
            w_sat = 32'sh7fffffff;
        end else if (w_ts[35] && (w_ts[34:31] != '1)) begin
            w_sat = 32'sh80000000;
        end else begin
            w_sat = t_coord'(w_ts[31:0]);
        end
    end

    assign o_pop_ready = (r_state == S_IDLE);
    assign w_emit      = (r_state == S_EMIT) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_job  <= i_head.job;
                        r_vec  <= 1'b0;
                        r_m[0] <= mag(i_head.job.d_x);
                        r_m[1] <= mag(i_head.job.d_y);
                        r_m[2] <= mag(i_head.job.d_z);
                        r_neg[0] <= i_head.job.d_x[DIFF_W-1];
                        r_neg[1] <= i_head.job.d_y[DIFF_W-1];
                        r_neg[2] <= i_head.job.d_z[DIFF_W-1];
                        r_cnt  <= '0;
                        if (i_head.job.deg) begin
                            for (int i = 0; i < 3; i++) begin
                                r_ez[i] <= '0;
                                r_ex[i] <= '0;
                            end
                            r_state <= S_CROSS;
                        end else begin
                            r_state <= S_SCALE;
                        end
                    end
                end
                S_SCALE: begin
                    if (w_hi) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (w_lo) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_prod <= w_prod;
                    if (r_cnt != 5'd0) begin
                        r_sum <= r_sum + 64'(r_prod);
                    end
                    if (r_cnt == 5'd3) begin
                        r_rad   <= r_sum + 64'(r_prod);
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_SQRT: begin
                    // one root bit per cycle
                    r_rad <= r_rad << 2;
                    if (w_sq_rem >= w_sq_trial) begin
                        r_rem  <= 33'(w_sq_rem - w_sq_trial);
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= 33'(w_sq_rem);
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_comp  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd0) begin
                        if (w_dv_m >= {1'b0, r_root}) begin
                            r_dr <= w_dv_m - {1'b0, r_root};
                            r_q  <= 31'd1;
                        end else begin
                            r_dr <= w_dv_m;
                            r_q  <= 31'd0;
                        end
                    end else if (r_cnt != 5'd31) begin
                        if (w_dr2 >= {2'b0, r_root}) begin
                            r_dr <= 33'(w_dr2 - {2'b0, r_root});
                            r_q  <= {r_q[29:0], 1'b1};
                        end else begin
                            r_dr <= 33'(w_dr2);
                            r_q  <= {r_q[29:0], 1'b0};
                        end
                    end else begin
                        if (r_vec) begin
                            r_ex[r_comp] <= w_coef;
                        end else begin
                            r_ez[r_comp] <= w_coef;
                        end
                        r_comp <= r_comp + 2'd1;
                        if (r_comp == 2'd2) begin
                            r_cnt <= '0;
                            if (r_vec) begin
                                r_state <= S_CROSS;
                            end else begin
                                // side vector is (dz, 0, -dx)
                                r_vec    <= 1'b1;
                                r_m[0]   <= mag(r_job.d_z);
                                r_m[1]   <= '0;
                                r_m[2]   <= mag(r_job.d_x);
                                r_neg[0] <= r_job.d_z[DIFF_W-1];
                                r_neg[1] <= 1'b0;
                                r_neg[2] <= !r_job.d_x[DIFF_W-1] && (r_job.d_x != '0);
                                r_state  <= S_SCALE;
                            end
                        end
                    end
                end
                S_CROSS: begin
                    r_prod <= w_prod;
                    r_cnt  <= r_cnt + 5'd1;
                    case (r_cnt)
                        5'd1: r_ey[0] <= rnd_q(r_prod);
                        5'd2: r_tmp   <= r_prod;
                        5'd3: r_ey[1] <= rnd_q(r_tmp - r_prod);
                        5'd4: begin
                            r_ey[2] <= rnd_q(-r_prod);
                            r_row   <= 2'd0;
                            r_cnt   <= '0;
                            r_state <= S_TRANS;
                        end
                        default: ;
                    endcase
                end
                S_TRANS: begin
                    r_prod <= w_prod;
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_acc <= '0;
                    end else begin
                        r_acc <= r_acc + {{2{r_prod[63]}}, r_prod};
                    end
                    if (r_cnt == 5'd3) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_shift <= w_sat;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_cnt <= '0;
                        if (r_row == 2'd2) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_row   <= r_row + 2'd1;
                            r_state <= S_TRANS;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (w_emit) begin
            r_out_row   <= r_row;
            r_out_cx    <= w_row_c[0];
            r_out_cy    <= w_row_c[1];
            r_out_cz    <= w_row_c[2];
            r_out_shift <= r_shift;
            r_out_last  <= (r_row == 2'd2);
            r_out_deg   <= r_job.deg;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = {6'b0, r_out_shift, r_out_cz, r_out_cy, r_out_cx, r_out_row};
    assign o_last  = r_out_last;
    assign o_deg   = r_out_deg;

endmodule

// File: tb/look_at_view_matrix_checker.sv
`timescale 1ns / 100ps

module look_at_view_matrix_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic [lav_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    input  logic [lav_pkg::OUT_W-1:0] i_m_tdata,
    input  logic                      i_m_tlast,
    input  logic                      i_m_tuser,
    output int                        o_errors,
    output int                        o_pending
);

    typedef longint t_vec[3];
    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic [1:0]  row;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [31:0] sh;
        logic        last;
        logic        deg;
    } t_row;

    t_row rows_due[$];

    function automatic t_wide wmul(input longint a, input longint b);
        t_wide x;
        t_wide y;
        x = a;
        y = b;
        return x * y;
    endfunction

    // floor(a / 2^30 + 1/2)
    function automatic t_wide round_q30(input t_wide a);
        t_wide half;
        half = 128'sd1 <<< 29;
        return (a + half) >>> 30;
    endfunction

    function automatic logic [31:0] sat32(input t_wide a);
        if (a > 128'sd2147483647) return 32'h7fffffff;
        if (a < -128'sd2147483648) return 32'h80000000;
        return a[31:0];
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned s);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit unit_vec(input t_vec v, output t_vec u);
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        longint unsigned r;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
            u[i] = 0;
        end
        if (mx == 0) return 0;
        while (mx >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            mx = mx << 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
        len = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] << 30) / len;
            r = (m[i] << 30) % len;
            if (2 * r >= len) q++;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    task automatic predict_view(input logic [lav_pkg::IN_W-1:0] data);
        t_vec eye;
        t_vec d;
        t_vec h;
        t_vec ex;
        t_vec ey;
        t_vec ez;
        t_vec r;
        t_wide acc;
        t_row e;
        bit deg;
        int a;
        int b;
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'($signed(data[32*i +: 32]));
            d[i] = eye[i] - longint'($signed(data[32*(i+3) +: 32]));
        end
        h[0] = d[2];
        h[1] = 0;
        h[2] = -d[0];
        deg = !unit_vec(d, ez);
        if (!deg) deg = !unit_vec(h, ex);
        for (int j = 0; j < 3; j++) begin
            a = (j + 1) % 3;
            b = (j + 2) % 3;
            ey[j] = deg ? 0 : longint'(round_q30(wmul(ez[a], ex[b]) - wmul(ez[b], ex[a])));
            if (deg) begin
                ex[j] = 0;
                ez[j] = 0;
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (i == 0) begin
                r = ex;
            end else if (i == 1) begin
                r = ey;
            end else begin
                r = ez;
            end
            acc = 0;
            for (int j = 0; j < 3; j++) acc = acc + wmul(r[j], eye[j]);
            e.row  = i[1:0];
            e.cx   = sat32(round_q30(wmul(r[0], 64'sd1 <<< 30)));
            e.cy   = sat32(round_q30(wmul(r[1], 64'sd1 <<< 30)));
            e.cz   = sat32(round_q30(wmul(r[2], 64'sd1 <<< 30)));
            e.sh   = sat32(round_q30(-acc));
            e.last = (i == 2);
            e.deg  = deg;
            rows_due.push_back(e);
        end
    endtask

    task automatic check_row();
        t_row e;
        t_row g;
        g.row  = i_m_tdata[1:0];
        g.cx   = i_m_tdata[33:2];
        g.cy   = i_m_tdata[65:34];
        g.cz   = i_m_tdata[97:66];
        g.sh   = i_m_tdata[129:98];
        g.last = i_m_tlast;
        g.deg  = i_m_tuser;
        if (rows_due.size() == 0) begin
            $display("%0t: unexpected row %0d", $time, g.row);
            o_errors++;
            return;
        end
        e = rows_due.pop_front();
        if (g != e) begin
            $display("%0t: row exp %0d %h %h %h %h last %b deg %b", $time,
                     e.row, e.cx, e.cy, e.cz, e.sh, e.last, e.deg);
            $display("%0t: row got %0d %h %h %h %h last %b deg %b", $time,
                     g.row, g.cx, g.cy, g.cz, g.sh, g.last, g.deg);
            o_errors++;
        end
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) predict_view(i_s_tdata);
            if (i_m_tvalid && i_m_tready) check_row();
        end
        o_pending <= rows_due.size();
    end

endmodule

// File: tb/look_at_view_matrix_tb.sv
`timescale 1ns / 100ps

module look_at_view_matrix_tb;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [lav_pkg::IN_W-1:0]  s_axis_tdata;   // eye_x,eye_y,eye_z,target_x,target_y,target_z
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [lav_pkg::OUT_W-1:0] m_axis_tdata;   // row_index,coeff_x,coeff_y,coeff_z,shift,pad
    logic                      m_axis_tlast;
    logic                      m_axis_tuser;   // degenerate
    int                        errors;
    int                        pending;
    int                        burst_left;

    look_at_view_matrix i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    look_at_view_matrix_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tlast  (m_axis_tlast),
        .i_m_tuser  (m_axis_tuser),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #7_200_000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_camera(input logic [31:0] ex, input logic [31:0] ey,
                               input logic [31:0] ez, input logic [31:0] tx,
                               input logic [31:0] ty, input logic [31:0] tz);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tdata  <= {tz, ty, tx, ez, ey, ex};
        s_axis_tvalid <= 1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            1: return 32'($signed(16'($urandom)));
            2: return 32'($signed(4'($urandom)));
            default: return $urandom;
        endcase
    endfunction

    // receiver: alternating always-ready and random-ready stretches, plus one long hold-off
    initial begin
        int cyc;
        m_axis_tready <= 0;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= 3000 && cyc < 6000)
                m_axis_tready <= 0;
            else if ((cyc / 300) % 2 == 0)
                m_axis_tready <= 1;
            else
                m_axis_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    initial begin
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] ez;
        logic [31:0] dy;
        s_axis_tvalid <= 0;
        s_axis_tdata  <= '0;
        i_rst_n       <= 0;
        burst_left    = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // eye on target, view along up, extremes, tiny and mixed-sign views
        send_camera(0, 0, 0, 0, 0, 0);
        send_camera(32'h00010000, 32'h00020000, 32'hfffd0000,
                    32'h00010000, 32'h00020000, 32'hfffd0000);
        send_camera(0, 32'h00050000, 0, 0, 0, 0);
        send_camera(32'h00030000, 32'h80000000, 32'h00030000,
                    32'h00030000, 32'h7fffffff, 32'h00030000);
        send_camera(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                    32'h80000000, 32'h80000000, 32'h80000000);
        send_camera(32'h80000000, 32'h80000000, 32'h80000000,
                    32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_camera(32'h7fffffff, 0, 32'h80000000, 32'h80000000, 0, 32'h7fffffff);
        send_camera(1, 0, 0, 0, 0, 0);
        send_camera(0, 0, 32'hffffffff, 0, 0, 0);
        send_camera(1, 1, 1, 0, 0, 0);
        send_camera(0, 0, 32'h00050000, 0, 0, 0);
        send_camera(32'h00050000, 0, 0, 0, 0, 0);
        send_camera(32'hfffb0000, 32'h00020000, 32'h00010000, 0, 0, 0);
        send_camera(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
        send_camera(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
        send_camera(32'h12345678, 32'h9abcdef0, 32'h0fedcba9,
                    32'h87654321, 32'h13579bdf, 32'h2468ace0);
        send_camera(32'hffffffff, 32'h80000000, 32'h7fffffff,
                    32'h00000001, 32'h00000000, 32'h80000001);

        for (int n = 0; n < 210; n++) begin
            ex = rand_coord();
            ey = rand_coord();
            ez = rand_coord();
            dy = rand_coord();
            case ($urandom_range(0, 19))
                0: send_camera(ex, ey, ez, ex, ey, ez);
                1: send_camera(ex, ey, ez, ex, dy, ez);
                2: send_camera(ex, ey, ez, ex + 32'($urandom_range(0, 2)) - 1, dy,
                               ez + 32'($urandom_range(0, 2)) - 1);
                default: send_camera(ex, ey, ez, rand_coord(), rand_coord(), rand_coord());
            endcase
        end
        s_axis_tvalid <= 0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
